### sv/lprt_pkg.sv
// Shared types and codes for the longest-prefix route table.
// Item structs, route entry layout, command/status/register codes.
// No dependencies.
`default_nettype none

package lprt_pkg;

   localparam int DATA_W = 32;
   localparam int SLOT_W = 5;
   localparam int CSR_IDX_W = 2;

   // commands
   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
   localparam logic [2:0] ST_UNREACHABLE = 3'd2;
   localparam logic [2:0] ST_COVERED     = 3'd3;
   localparam logic [2:0] ST_FULL        = 3'd4;
   localparam logic [2:0] ST_EMPTY       = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PORT0_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT0_MASK    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT1_ADDRESS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT1_MASK    = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [DATA_W-1:0] address;
      logic [DATA_W-1:0] prefix_mask;
      logic [DATA_W-1:0] gateway;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [DATA_W-1:0] next_hop;
      logic              exit_port;
      logic [SLOT_W-1:0] hit_slot;
      logic [DATA_W-1:0] hit_mask;
   } rsp_type;

   // one table entry as stored in the route memory
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] prefix;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] gateway;
      logic              port;
   } route_type;

   // running result of a table scan
   typedef struct packed {
      logic              found;
      logic              free_found;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] gateway;
      logic              port;
   } match_type;

endpackage

`default_nettype wire

### sv/lprt_route_mem.sv
// Route table storage: one write port, one read port with registered data.
// Depends on lprt_pkg (route_type).
`default_nettype none

module lprt_route_mem #(
   parameter int ENTRIES = 32,
   parameter int IDX_W   = 5
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [IDX_W-1:0]         wr_addr,
   input  lprt_pkg::route_type      wr_data,
   input  wire                      rd_en,
   input  wire  [IDX_W-1:0]         rd_addr,
   output lprt_pkg::route_type      rd_data
);
   import lprt_pkg::*;

   route_type route_ram [ENTRIES];
   route_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_ram[wr_addr] <= wr_data;
      end
   end

   // read port, data registered and valid in the cycle after the address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= route_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/lprt_match_unit.sv
// Shared compare unit: checks one table entry per cycle against the key
// while eval_en is high, keeps the longest matching route and the lowest
// free slot seen so far. Depends on lprt_pkg (route_type, match_type).
`default_nettype none

module lprt_match_unit #(
   parameter int IDX_W = 5
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      clear,
   input  wire                      eval_en,
   input  wire  [31:0]              key_addr,
   input  lprt_pkg::route_type      entry,
   input  wire  [IDX_W-1:0]         entry_idx,
   output lprt_pkg::match_type      match,
   output logic [IDX_W-1:0]         best_idx,
   output logic [IDX_W-1:0]         free_idx
);
   import lprt_pkg::*;

   logic              found_ff;
   logic              free_found_ff;
   logic [DATA_W-1:0] mask_ff;
   logic [DATA_W-1:0] gateway_ff;
   logic              port_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              hit;
   logic              better;
   logic              take_free;

   // strict greater keeps the lowest slot on equal masks
   always_comb begin
      hit       = entry.valid && (((entry.prefix ^ key_addr) & entry.mask) == '0);
      better    = hit && (!found_ff || (entry.mask > mask_ff));
      take_free = !entry.valid && !free_found_ff;
   end

   // flags
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (eval_en) begin
         if (better) begin
            found_ff <= 1'b1;
         end
         if (take_free) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   // captured route and slot
   always_ff @(posedge clock) begin
      if (eval_en && better) begin
         mask_ff     <= entry.mask;
         gateway_ff  <= entry.gateway;
         port_ff     <= entry.port;
         best_idx_ff <= entry_idx;
      end
      if (eval_en && take_free) begin
         free_idx_ff <= entry_idx;
      end
   end

   always_comb begin
      match.found      = found_ff;
      match.free_found = free_found_ff;
      match.mask       = mask_ff;
      match.gateway    = gateway_ff;
      match.port       = port_ff;
      best_idx         = best_idx_ff;
      free_idx         = free_idx_ff;
   end

endmodule

`default_nettype wire

### sv/longest_prefix_route_table_unit.sv
// Longest-prefix route table. A lookup or an add walks the whole table through
// the single read port of the route memory, one slot per cycle, with one shared
// compare unit. Such an item scans every slot through the registered read port,
// then decides, then hands its result to the output register; only after
// that hand-off is the next item taken. A delete reads its slot, checks and
// clears it, then hands off its result the same way. A lookup on an empty
// table, a delete of a slot beyond the table or an unknown command goes
// straight to the hand-off of its result.
// After reset a clearing pass invalidates every slot; req_ready stays low
// until it ends, while configuration writes are taken at any time. A
// finished result waits in the output register; the next item is accepted
// and worked meanwhile, and only its own hand-off waits for the slot.
// Depends on lprt_pkg, lprt_route_mem, lprt_match_unit.
`default_nettype none

module longest_prefix_route_table_unit #(
   parameter int ENTRIES = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_ready,
   input  lprt_pkg::req_type                 req_payload,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output lprt_pkg::rsp_type                 rsp_payload,
   // configuration writes
   input  wire                               csr_we,
   input  wire  [lprt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [lprt_pkg::DATA_W-1:0]       csr_wdata
);
   import lprt_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_DECIDE  = 3'd3;
   localparam logic [2:0] S_DEL_RD  = 3'd4;
   localparam logic [2:0] S_DEL_CHK = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     pend_idx_ff, pend_idx_in;
   req_type           key_ff, key_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;
   logic [DATA_W-1:0] port0_address_ff, port0_mask_ff;
   logic [DATA_W-1:0] port1_address_ff, port1_mask_ff;

   logic              wr_en, rd_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   route_type         wr_data, rd_data;
   logic              scan_clear;
   match_type         match;
   logic [IW-1:0]     best_idx, free_idx;
   logic              on_port0, on_port1;

   lprt_route_mem #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lprt_match_unit #(
      .IDX_W (IW)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .clear     (scan_clear),
      .eval_en   (pend_ff),
      .key_addr  (key_ff.address),
      .entry     (rd_data),
      .entry_idx (pend_idx_ff),
      .match     (match),
      .best_idx  (best_idx),
      .free_idx  (free_idx)
   );

   // gateway reachability, port 0 first
   always_comb begin
      on_port0 = (port0_address_ff & port0_mask_ff) == (key_ff.gateway & port0_mask_ff);
      on_port1 = (port1_address_ff & port1_mask_ff) == (key_ff.gateway & port1_mask_ff);
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      count_in       = count_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      key_in         = key_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      scan_clear     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IW-1:0];
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               key_in     = req_payload;
               res_in     = '0;
               scan_clear = 1'b1;
               cnt_in     = '0;
               case (req_payload.command)
                  CMD_LOOKUP: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_ADD: begin
                     state_in = S_SCAN;
                  end
                  CMD_DELETE: begin
                     if (32'(req_payload.slot) < 32'(ENTRIES)) begin
                        state_in = S_DEL_RD;
                     end else begin
                        res_in.status = ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end
                  end
                  default: begin
                     res_in.status = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read slot cnt, the compare unit sees it in the next cycle
            if (cnt_ff != CW'(ENTRIES)) begin
               rd_en       = 1'b1;
               rd_addr     = cnt_ff[IW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = cnt_ff[IW-1:0];
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            if (key_ff.command == CMD_LOOKUP) begin
               if (match.found) begin
                  res_in.status    = ST_OK;
                  res_in.next_hop  = match.gateway;
                  res_in.exit_port = match.port;
                  res_in.hit_slot  = SLOT_W'(best_idx);
                  res_in.hit_mask  = match.mask;
               end else begin
                  res_in.status = ST_NOT_FOUND;
               end
            end else if (match.found && (match.mask != '0)) begin
               res_in.status = ST_COVERED;
            end else if (!on_port0 && !on_port1) begin
               res_in.status = ST_UNREACHABLE;
            end else if (!match.free_found) begin
               res_in.status = ST_FULL;
            end else begin
               wr_en            = 1'b1;
               wr_addr          = free_idx;
               wr_data.valid    = 1'b1;
               wr_data.prefix   = key_ff.address & key_ff.prefix_mask;
               wr_data.mask     = key_ff.prefix_mask;
               wr_data.gateway  = key_ff.gateway;
               wr_data.port     = !on_port0;
               count_in         = count_ff + CW'(1);
               res_in.status    = ST_OK;
               res_in.next_hop  = key_ff.gateway;
               res_in.exit_port = !on_port0;
               res_in.hit_slot  = SLOT_W'(free_idx);
               res_in.hit_mask  = key_ff.prefix_mask;
            end
         end
         S_DEL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = IW'(key_ff.slot);
            state_in = S_DEL_CHK;
         end
         S_DEL_CHK: begin
            state_in = S_DONE;
            if (rd_data.valid) begin
               wr_en           = 1'b1;
               wr_addr         = IW'(key_ff.slot);
               wr_data         = rd_data;
               wr_data.valid   = 1'b0;
               count_in        = count_ff - CW'(1);
               res_in.status   = ST_OK;
               res_in.hit_slot = key_ff.slot;
            end else begin
               res_in.status = ST_NOT_FOUND;
            end
         end
         S_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      key_ff         <= key_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         port0_address_ff <= '0;
         port0_mask_ff    <= '0;
         port1_address_ff <= '0;
         port1_mask_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PORT0_ADDRESS: port0_address_ff <= csr_wdata;
            CSR_PORT0_MASK:    port0_mask_ff    <= csr_wdata;
            CSR_PORT1_ADDRESS: port1_address_ff <= csr_wdata;
            CSR_PORT1_MASK:    port1_mask_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // table writes only come from the clearing pass, an add or a delete
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_DECIDE || state_ff == S_DEL_CHK))
      else $error("route memory written outside clear/add/delete");

   // route count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(ENTRIES))
      else $error("route count above table size");

   // an accepted item always starts work
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item left the sequencer idle");

   // compare unit only sees data during a scan
   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN))
      else $error("compare unit enabled outside a scan");

   // add result with ok status always carries a free slot
   a_add_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && wr_en) |-> match.free_found)
      else $error("route stored without a free slot");

endmodule

`default_nettype wire
